[sv/txof_pkg.sv]
// Package: types, codes and constants of the transmit opportunity finder.
package txof_pkg;

   localparam int DEFAULT_UL_ENTRIES = 8;
   localparam int DEFAULT_DL_ENTRIES = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REQ_ADD = 2'd0;
   localparam logic [1:0] REQ_BEACON = 2'd1;
   localparam logic [1:0] REQ_FIND = 2'd2;
   localparam logic [1:0] REQ_CLOSEST = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VAL_BEACON = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VAL_NOW = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TURNAROUND = 2'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NONE = 3'd1;
   localparam logic [2:0] ST_OUTSIDE = 3'd2;
   localparam logic [2:0] ST_OVERLAP = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic        direction;
      logic [63:0] time_now;
      logic [63:0] tx_earliest;
      logic [63:0] beacon_time;
      logic [31:0] res_offset;
      logic [31:0] res_length;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] tx_time;
      logic [31:0] tx_length;
      logic [63:0] closest_delta;
   } rsp_word_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_WIN,
      S_DIV,
      S_BASE,
      S_SCAN,
      S_ADD,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic win;
      logic div_start;
      logic base;
      logic scan_step;
      logic scan_start;
      logic add_commit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       div_done;
      logic       scan_done;
   } sts_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return s;
   endfunction

   function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) begin
         s = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return s;
   endfunction

   function automatic logic [63:0] mag(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

endpackage

[sv/txof_if.sv]
// Interfaces: request and response channels with valid/ready handshake.
interface txof_req_if;
   logic                  valid;
   logic                  ready;
   txof_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface txof_rsp_if;
   logic                  valid;
   logic                  ready;
   txof_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[sv/txof_ctrl.sv]
// Controller: sequences one request through the datapath.
module txof_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  txof_pkg::sts_type   sts,
   output txof_pkg::cmd_type   cmd
);
   txof_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= txof_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         txof_pkg::S_IDLE: begin
            if (req_valid) state_in = txof_pkg::S_PREP;
         end
         txof_pkg::S_PREP: begin
            case (sts.req_type)
               txof_pkg::REQ_ADD: state_in = txof_pkg::S_SCAN;
               txof_pkg::REQ_BEACON: state_in = txof_pkg::S_DONE;
               txof_pkg::REQ_FIND: state_in = txof_pkg::S_WIN;
               default: state_in = txof_pkg::S_SCAN;
            endcase
         end
         txof_pkg::S_WIN: state_in = txof_pkg::S_DIV;
         txof_pkg::S_DIV: begin
            if (sts.div_done) state_in = txof_pkg::S_BASE;
         end
         txof_pkg::S_BASE: state_in = txof_pkg::S_SCAN;
         txof_pkg::S_SCAN: begin
            if (sts.scan_done) begin
               state_in = (sts.req_type == txof_pkg::REQ_ADD) ? txof_pkg::S_ADD
                                                              : txof_pkg::S_DONE;
            end
         end
         txof_pkg::S_ADD: state_in = txof_pkg::S_DONE;
         txof_pkg::S_DONE: begin
            if (rsp_ready) state_in = txof_pkg::S_IDLE;
         end
         default: state_in = txof_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         txof_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         txof_pkg::S_PREP: begin
            cmd.prep = 1'b1;
            cmd.scan_start = 1'b1;
         end
         txof_pkg::S_WIN: begin
            cmd.win = 1'b1;
            cmd.div_start = 1'b1;
         end
         txof_pkg::S_DIV: ;
         txof_pkg::S_BASE: begin
            cmd.base = 1'b1;
            cmd.scan_start = 1'b1;
         end
         txof_pkg::S_SCAN: cmd.scan_step = 1'b1;
         txof_pkg::S_ADD: cmd.add_commit = 1'b1;
         txof_pkg::S_DONE: begin
            rsp_valid = 1'b1;
            cmd.finish = rsp_ready;
         end
         default: ;
      endcase
   end
endmodule

[sv/txof_div.sv]
// Divider: restoring 64-by-32 unsigned division, one quotient bit a cycle.
module txof_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic [31:0] remainder,
   output logic        done
);
   logic [63:0] q_ff, q_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff, q_ff[63]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = 32'(trial - {1'b0, d_ff});
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = trial[31:0];
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign remainder = r_ff;
   assign done = !busy_ff && !start;
endmodule

[sv/txof_dp.sv]
// Datapath: resource tables, beacon state, window, walk and closest search.
module txof_dp #(
   parameter int MaxUl = txof_pkg::DEFAULT_UL_ENTRIES,
   parameter int MaxDl = txof_pkg::DEFAULT_DL_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  txof_pkg::req_word_type        req_data,
   input  logic                          csr_we,
   input  logic [txof_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [txof_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  txof_pkg::cmd_type             cmd,
   output txof_pkg::sts_type             sts,
   output txof_pkg::rsp_word_type        rsp_data
);
   localparam int UlW = $clog2(MaxUl + 1);
   localparam int DlW = $clog2(MaxDl + 1);
   localparam int CntW = (UlW > DlW) ? UlW : DlW;
   localparam int MaxE = (MaxUl > MaxDl) ? MaxUl : MaxDl;
   localparam int IdxW = (MaxE > 1) ? $clog2(MaxE) : 1;

   logic [31:0] period_ff, vab_ff, van_ff, turn_ff;
   logic [31:0] ul_off_ff [MaxUl];
   logic [31:0] ul_len_ff [MaxUl];
   logic [31:0] dl_off_ff [MaxDl];
   logic [31:0] dl_len_ff [MaxDl];
   logic [UlW-1:0] ul_cnt_ff;
   logic [DlW-1:0] dl_cnt_ff;
   logic [63:0] beacon_ff;
   logic        known_ff;

   txof_pkg::req_word_type rq_ff;
   logic [63:0] early_ff, late_ff, base_ff, best_ff;
   logic [CntW-1:0] idx_ff;
   logic [1:0]  pass_ff;
   logic        done_ff, found_ff;
   logic [2:0]  status_ff;
   logic [63:0] tx_time_ff, delta_ff;
   logic [31:0] tx_len_ff;

   logic [31:0] per_eff;
   logic        use_dl;
   logic [CntW-1:0] count;
   logic [CntW-1:0] cap;
   logic [31:0] e_off, e_len;
   logic [IdxW-1:0] rd_idx;
   logic [31:0] div_r;
   logic        div_done;
   logic [63:0] l1, l2, earliest_c, d_c, a_c;
   logic [32:0] end_sum;

   assign per_eff = (period_ff == 32'd0) ? 32'd1 : period_ff;
   assign use_dl = rq_ff.direction && (rq_ff.req_type != txof_pkg::REQ_CLOSEST);
   assign count = use_dl ? CntW'(dl_cnt_ff) : CntW'(ul_cnt_ff);
   assign cap = use_dl ? CntW'(MaxDl) : CntW'(MaxUl);
   assign rd_idx = idx_ff[IdxW-1:0];

   always_comb begin
      e_off = '0;
      e_len = '0;
      if (use_dl) begin
         if (32'(rd_idx) < 32'(MaxDl)) begin
            e_off = dl_off_ff[rd_idx];
            e_len = dl_len_ff[rd_idx];
         end
      end else if (32'(rd_idx) < 32'(MaxUl)) begin
         e_off = ul_off_ff[rd_idx];
         e_len = ul_len_ff[rd_idx];
      end
   end

   txof_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (rq_ff.tx_earliest - beacon_ff),
      .divisor   (per_eff),
      .remainder (div_r),
      .done      (div_done)
   );

   assign l1 = txof_pkg::sat_add(beacon_ff, {32'd0, vab_ff});
   assign l2 = txof_pkg::sat_add(rq_ff.time_now, {32'd0, van_ff});
   assign earliest_c = ($signed(rq_ff.tx_earliest) >
                        $signed(txof_pkg::sat_add(rq_ff.time_now, {32'd0, turn_ff})))
                       ? rq_ff.tx_earliest
                       : txof_pkg::sat_add(rq_ff.time_now, {32'd0, turn_ff});
   assign d_c = txof_pkg::sat_add(base_ff, {32'd0, e_off});
   assign a_c = txof_pkg::sat_sub(rq_ff.time_now, d_c);
   assign end_sum = {1'b0, rq_ff.res_offset} + {1'b0, rq_ff.res_length};

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 32'd1;
         vab_ff <= '0;
         van_ff <= '0;
         turn_ff <= '0;
         ul_cnt_ff <= '0;
         dl_cnt_ff <= '0;
         beacon_ff <= '0;
         known_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_idx)
               txof_pkg::CSR_PERIOD: period_ff <= csr_wdata;
               txof_pkg::CSR_VAL_BEACON: vab_ff <= csr_wdata;
               txof_pkg::CSR_VAL_NOW: van_ff <= csr_wdata;
               txof_pkg::CSR_TURNAROUND: turn_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.prep && rq_ff.req_type == txof_pkg::REQ_BEACON) begin
            beacon_ff <= rq_ff.beacon_time;
            known_ff <= 1'b1;
         end
         if (cmd.add_commit && status_ff == txof_pkg::ST_OK) begin
            if (rq_ff.direction) dl_cnt_ff <= dl_cnt_ff + DlW'(1);
            else ul_cnt_ff <= ul_cnt_ff + UlW'(1);
         end
         if (cmd.scan_start) done_ff <= 1'b0;
         else if (cmd.scan_step) begin
            if (rq_ff.req_type == txof_pkg::REQ_ADD) begin
               if (status_ff != txof_pkg::ST_OK || idx_ff >= count || idx_ff >= cap)
                  done_ff <= 1'b1;
            end else if (rq_ff.req_type == txof_pkg::REQ_CLOSEST) begin
               if (idx_ff + CntW'(1) >= count || done_ff) done_ff <= 1'b1;
            end else begin
               if (done_ff || count == '0) done_ff <= 1'b1;
               else if ($signed(rq_ff.tx_earliest) <= $signed(d_c) &&
                        $signed(d_c) < $signed(late_ff)) done_ff <= 1'b1;
               else if ($signed(late_ff) <= $signed(d_c)) done_ff <= 1'b1;
               else if (idx_ff + CntW'(1) >= count && pass_ff == 2'd2) done_ff <= 1'b1;
            end
         end
      end

      if (cmd.add_commit && status_ff == txof_pkg::ST_OK) begin
         if (rq_ff.direction) begin
            dl_off_ff[IdxW'(dl_cnt_ff)] <= rq_ff.res_offset;
            dl_len_ff[IdxW'(dl_cnt_ff)] <= rq_ff.res_length;
         end else begin
            ul_off_ff[IdxW'(ul_cnt_ff)] <= rq_ff.res_offset;
            ul_len_ff[IdxW'(ul_cnt_ff)] <= rq_ff.res_length;
         end
      end

      if (cmd.load) rq_ff <= req_data;

      if (cmd.prep) begin
         idx_ff <= '0;
         pass_ff <= '0;
         found_ff <= 1'b0;
         tx_time_ff <= '0;
         tx_len_ff <= '0;
         delta_ff <= '0;
         base_ff <= beacon_ff;
         status_ff <= txof_pkg::ST_NONE;
         case (rq_ff.req_type)
            txof_pkg::REQ_ADD: begin
               if (rq_ff.res_length == 32'd0 || end_sum - 33'd1 >= {1'b0, per_eff})
                  status_ff <= txof_pkg::ST_OUTSIDE;
               else status_ff <= txof_pkg::ST_OK;
            end
            txof_pkg::REQ_BEACON: status_ff <= txof_pkg::ST_OK;
            txof_pkg::REQ_CLOSEST: begin
               if (!known_ff || ul_cnt_ff == '0) begin
                  status_ff <= txof_pkg::ST_NONE;
                  idx_ff <= CntW'(MaxE);
               end else status_ff <= txof_pkg::ST_OK;
            end
            default: ;
         endcase
         rq_ff.tx_earliest <= earliest_c;
      end

      if (cmd.win) begin
         late_ff <= rq_ff.direction
                    ? txof_pkg::sat_add(beacon_ff, {32'd0, per_eff})
                    : (($signed(l1) < $signed(l2)) ? l1 : l2);
         early_ff <= rq_ff.tx_earliest;
      end

      if (cmd.base) begin
         if ($signed(early_ff) > $signed(beacon_ff))
            base_ff <= early_ff - {32'd0, div_r};
         if (!known_ff || $signed(early_ff) > $signed(late_ff)) pass_ff <= 2'd3;
      end

      if (cmd.scan_step && !done_ff) begin
         case (rq_ff.req_type)
            txof_pkg::REQ_ADD: begin
               if (status_ff == txof_pkg::ST_OK) begin
                  if (idx_ff < count && idx_ff < cap) begin
                     if ({1'b0, rq_ff.res_offset} < {1'b0, e_off} + {1'b0, e_len} &&
                         {1'b0, e_off} < end_sum)
                        status_ff <= txof_pkg::ST_OVERLAP;
                     idx_ff <= idx_ff + CntW'(1);
                  end else if (count >= cap) status_ff <= txof_pkg::ST_FULL;
               end
            end
            txof_pkg::REQ_CLOSEST: begin
               if (idx_ff < count) begin
                  if (idx_ff == '0 || txof_pkg::mag(a_c) < best_ff) begin
                     best_ff <= txof_pkg::mag(a_c);
                     delta_ff <= a_c;
                  end
                  idx_ff <= idx_ff + CntW'(1);
               end
            end
            default: begin
               if (pass_ff != 2'd3 && count != '0) begin
                  if ($signed(rq_ff.tx_earliest) <= $signed(d_c) &&
                      $signed(d_c) < $signed(late_ff)) begin
                     found_ff <= 1'b1;
                     tx_time_ff <= d_c;
                     tx_len_ff <= e_len;
                     status_ff <= txof_pkg::ST_OK;
                  end else if (idx_ff + CntW'(1) >= count) begin
                     idx_ff <= '0;
                     pass_ff <= pass_ff + 2'd1;
                     base_ff <= txof_pkg::sat_add(base_ff, {32'd0, per_eff});
                  end else idx_ff <= idx_ff + CntW'(1);
               end
            end
         endcase
      end
   end

   assign sts.req_type = rq_ff.req_type;
   assign sts.div_done = div_done;
   assign sts.scan_done = done_ff || (rq_ff.req_type == txof_pkg::REQ_FIND &&
                                      (pass_ff == 2'd3 || count == '0));

   always_comb begin
      rsp_data.status = status_ff;
      rsp_data.tx_time = '0;
      rsp_data.tx_length = '0;
      rsp_data.closest_delta = '0;
      if (rq_ff.req_type == txof_pkg::REQ_FIND && found_ff) begin
         rsp_data.tx_time = tx_time_ff;
         rsp_data.tx_length = tx_len_ff;
      end
      if (rq_ff.req_type == txof_pkg::REQ_CLOSEST && status_ff == txof_pkg::ST_OK)
         rsp_data.closest_delta = delta_ff;
   end
endmodule

[sv/tx_opportunity_finder_unit.sv]
// Top level: transmit opportunity finder with request/response channels.
// One request is handled at a time. Add requests scan the table selected
// by direction and closest requests the uplink table, one entry per cycle.
// A find request runs a bit-serial 64-by-32 divider to locate the
// period boundary, then walks the table one entry per cycle for up to
// three periods. The response is held until taken; the next request
// is accepted after that.
module tx_opportunity_finder_unit #(
   parameter int MAX_UL_ENTRIES = txof_pkg::DEFAULT_UL_ENTRIES,
   parameter int MAX_DL_ENTRIES = txof_pkg::DEFAULT_DL_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   txof_req_if.sink                        req,
   txof_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  logic [txof_pkg::CSR_IDX_W-1:0]  csr_idx,
   input  logic [txof_pkg::CSR_DATA_W-1:0] csr_wdata
);
   txof_pkg::cmd_type cmd;
   txof_pkg::sts_type sts;

   txof_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   txof_dp #(
      .MaxUl (MAX_UL_ENTRIES),
      .MaxDl (MAX_DL_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req.data),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp.data)
   );
endmodule
